>>> design/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types, widths, codes and defaults of the two-queue port scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

  // payload widths fixed by the beat formats
  localparam int HANDLE_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int LIMIT_W    = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // parameter defaults
  localparam int MGMT_DEPTH_DEF  = 64;
  localparam int DATA_DEPTH_DEF  = 1024;
  localparam int HANDLE_BITS_DEF = 16;

  // register reset and addresses
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = LIMIT_W'(1000);
  localparam logic [CFG_ADDR_W-1:0] ADDR_DATA_LIMIT = CFG_ADDR_W'(0);

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DATA_DROP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MGMT_DROP = 2'd3;

  // queue status toward the scheduler
  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

`default_nettype wire

>>> design/ptq_if.sv
// ----------------------------------------------------------------------------
// ptq_if
// Valid/ready channels: the command channel in and the result channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptq_cmd_if import ptq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic                is_mgmt;
  logic [HANDLE_W-1:0] pdu_handle;

  modport source (output valid, cmd, is_mgmt, pdu_handle, input ready);
  modport sink   (input valid, cmd, is_mgmt, pdu_handle, output ready);
endinterface

interface ptq_res_if import ptq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_is_mgmt;

  modport source (output valid, status, out_valid, out_handle, out_is_mgmt, input ready);
  modport sink   (input valid, status, out_valid, out_handle, out_is_mgmt, output ready);
endinterface

`default_nettype wire

>>> design/ptq_fifo.sv
// ----------------------------------------------------------------------------
// ptq_fifo
// Circular handle queue: one memory, head/tail pointers, fill count, limit
// compare, and a registered read port that loads on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_fifo import ptq_pkg::*; #(
  parameter int DEPTH = DATA_DEPTH_DEF,
  parameter int WIDTH = HANDLE_W,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             pop,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [CW-1:0]    limit,
  output qstat_t                stat,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic [CW-1:0]    count;

  assign stat.full     = (count >= limit);
  assign stat.nonempty = (count != '0);

  // write at tail, read at head into the read register
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wdata;
    end
    if (pop) begin
      rd_data <= mem[head];
    end
  end

  // advance pointers with wrap at depth, track the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no push into a full queue, no pop from an empty one
  assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> stat.nonempty)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("fill count did not advance on push");

endmodule

`default_nettype wire

>>> design/ptq_cfg.sv
// ----------------------------------------------------------------------------
// ptq_cfg
// APB register file holding the data queue limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_cfg import ptq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [LIMIT_W-1:0]    data_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_DATA_LIMIT);

  // write the limit on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      data_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      data_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // read back
  always_comb begin
    if (paddr == ADDR_DATA_LIMIT) begin
      prdata = CFG_DATA_W'(data_limit);
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

>>> design/priority_two_queue_tail_drop.sv
// ----------------------------------------------------------------------------
// priority_two_queue_tail_drop
// Strict-priority output scheduler with a management and a data handle queue.
// ----------------------------------------------------------------------------
// One command beat is taken per clock while the command channel is not
// stalled. Its result beat appears in the cycle after acceptance from a single
// result register; the queue memories read through registered ports that load
// at the same edge. The command channel stalls only while a result waits and
// the result sink is not ready. Management handles always leave first.
// Data enqueues are dropped once the data queue holds min(data_limit,
// DATA_DEPTH) entries; management enqueues are dropped when that queue is
// full. After reset both queues are empty and data_limit is 1000; no clearing
// pass is needed.
`default_nettype none

module priority_two_queue_tail_drop import ptq_pkg::*; #(
  parameter int MGMT_DEPTH  = MGMT_DEPTH_DEF,
  parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ptq_cmd_if.sink                    req,
  ptq_res_if.source                  rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int SW  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int MCW = $clog2(MGMT_DEPTH + 1);
  localparam int DCW = $clog2(DATA_DEPTH + 1);

  logic [LIMIT_W-1:0] data_limit;
  logic [DCW-1:0]     data_lim_eff;
  qstat_t             mgmt_stat;
  qstat_t             data_stat;
  logic [SW-1:0]      mgmt_rd;
  logic [SW-1:0]      data_rd;
  logic               take;
  logic               mgmt_push;
  logic               mgmt_pop;
  logic               data_push;
  logic               data_pop;
  logic [STATUS_W-1:0] status_next;
  logic               res_valid;
  logic [STATUS_W-1:0] res_status;
  logic               res_pkt;
  logic               res_mgmt;

  ptq_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .data_limit (data_limit)
  );

  // saturate the limit to the data depth
  always_comb begin
    if (32'(data_limit) > 32'(DATA_DEPTH)) begin
      data_lim_eff = DCW'(DATA_DEPTH);
    end else begin
      data_lim_eff = DCW'(data_limit);
    end
  end

  // accept while the result register is free or draining
  assign req.ready = !res_valid || rsp.ready;
  assign take      = req.valid && req.ready;

  // steer the beat to a queue
  always_comb begin
    mgmt_push   = 1'b0;
    mgmt_pop    = 1'b0;
    data_push   = 1'b0;
    data_pop    = 1'b0;
    status_next = ST_OK;
    case (req.cmd)
      CMD_ENQ: begin
        if (req.is_mgmt) begin
          if (mgmt_stat.full) status_next = ST_MGMT_DROP;
          else                mgmt_push   = take;
        end else begin
          if (data_stat.full) status_next = ST_DATA_DROP;
          else                data_push   = take;
        end
      end
      CMD_DEQ: begin
        if (mgmt_stat.nonempty)      mgmt_pop    = take;
        else if (data_stat.nonempty) data_pop    = take;
        else                         status_next = ST_EMPTY;
      end
      default: status_next = ST_OK;
    endcase
  end

  ptq_fifo #(.DEPTH(MGMT_DEPTH), .WIDTH(SW)) u_mgmt_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mgmt_push),
    .pop     (mgmt_pop),
    .wdata   (req.pdu_handle[SW-1:0]),
    .limit   (MCW'(MGMT_DEPTH)),
    .stat    (mgmt_stat),
    .rd_data (mgmt_rd)
  );

  ptq_fifo #(.DEPTH(DATA_DEPTH), .WIDTH(SW)) u_data_q (
    .clk     (clk),
    .rst     (rst),
    .push    (data_push),
    .pop     (data_pop),
    .wdata   (req.pdu_handle[SW-1:0]),
    .limit   (data_lim_eff),
    .stat    (data_stat),
    .rd_data (data_rd)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_status <= status_next;
      res_pkt    <= mgmt_pop || data_pop;
      res_mgmt   <= mgmt_pop;
    end
  end

  // drive the result beat; handle comes from the popped queue's read register
  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.out_valid   = res_pkt;
  assign rsp.out_is_mgmt = res_pkt && res_mgmt;
  assign rsp.out_handle  = !res_pkt ? '0
                         : res_mgmt ? HANDLE_W'(mgmt_rd) : HANDLE_W'(data_rd);

  // a popped packet always reports success
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_valid) |-> rsp.status == ST_OK)
    else $error("packet beat with non-ok status");
  // management has priority on dequeue
  assert property (@(posedge clk) disable iff (rst)
    (take && req.cmd == CMD_DEQ && mgmt_stat.nonempty) |=> rsp.out_is_mgmt)
    else $error("dequeue skipped nonempty management queue");
  // an enqueue never produces a packet or an empty report
  assert property (@(posedge clk) disable iff (rst)
    (take && req.cmd == CMD_ENQ) |=> (!rsp.out_valid && rsp.status != ST_EMPTY))
    else $error("enqueue produced dequeue result");

endmodule

`default_nettype wire
